// ===== sv/isc_pkg.sv =====
// ----------------------------------------------------------------------------
// IMU sample conditioning package
// Shared types, constants and the 32-bit saturation function.
// ----------------------------------------------------------------------------
package isc_pkg;

   localparam int unsigned CALIB_SAMPLES = 50000;
   localparam int unsigned CALIB_HALF    = CALIB_SAMPLES / 2;
   localparam int          DIV_W         = $clog2(CALIB_SAMPLES + 1);
   localparam int          SUM_W         = 48;
   localparam int          DSTEP_W       = $clog2(SUM_W);
   localparam int          CNT_W         = 16;
   localparam int          CSR_IDX_W     = 3;

   // The new-sample weight of the low-pass, 0.3 in Q0.16.
   localparam logic [15:0] COEF_NEW = 16'd19661;

   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_SCALE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GYRO_SCALE   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_ZERO_X = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_ZERO_Y = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_ZERO_Z = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_GYRO_ZERO_X  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_GYRO_ZERO_Y  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_GYRO_ZERO_Z  = 3'd7;

   localparam logic signed [49:0] S32_MAX = 50'sd2147483647;
   localparam logic signed [49:0] S32_MIN = -50'sd2147483648;

   typedef struct packed {
      logic               accel_ready;
      logic               gyro_ready;
      logic signed [15:0] raw_accel_x;
      logic signed [15:0] raw_accel_y;
      logic signed [15:0] raw_accel_z;
      logic signed [15:0] raw_gyro_x;
      logic signed [15:0] raw_gyro_y;
      logic signed [15:0] raw_gyro_z;
      logic               calib_start;
   } req_type;

   typedef struct packed {
      logic signed [31:0] filt_accel_x;
      logic signed [31:0] filt_accel_y;
      logic signed [31:0] filt_accel_z;
      logic signed [31:0] corr_gyro_x;
      logic signed [31:0] corr_gyro_y;
      logic signed [31:0] corr_gyro_z;
      logic               calib_done;
      logic signed [31:0] avg_gyro_x;
      logic signed [31:0] avg_gyro_y;
      logic signed [31:0] avg_gyro_z;
   } rsp_type;

   function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
      logic signed [31:0] r;
      if (v > S32_MAX) begin
         r = 32'sh7FFFFFFF;
      end else if (v < S32_MIN) begin
         r = 32'sh80000000;
      end else begin
         r = $signed(v[31:0]);
      end
      return r;
   endfunction

endpackage

// ===== sv/imu_sample_condition_unit.sv =====
// ----------------------------------------------------------------------------
// IMU sample conditioning unit
// Scales raw accel and gyro samples, removes offsets, low-passes the accel
// axes and runs an optional gyro offset calibration with rounded means.
// ----------------------------------------------------------------------------
//
// Channel   Ports                          Moves
// req       req_valid/req_ready/req_data   one data-ready event
// rsp       rsp_valid/rsp_ready/rsp_data   one conditioned result
// csr       csr_we/csr_index/csr_wdata     one register write, no wait
//
// An event that completes calibration adds three serial divisions, one per
// gyro axis. The time an event takes comes from the shared multiplier,
// which takes four 4-bit digits per product, and the restoring divider,
// which takes one quotient bit a cycle.
// Reset clears the filter state, scales, offsets and calibration at once.
// A new event is taken while the last result waits; the unit only holds in
// its final state when the result register is still occupied.
module imu_sample_condition_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  isc_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output isc_pkg::rsp_type                    rsp_data,
   input  logic                                csr_we,
   input  logic [isc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [31:0]                         csr_wdata
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_MLOAD = 4'd1;
   localparam logic [3:0] ST_MUL   = 4'd2;
   localparam logic [3:0] ST_SCL   = 4'd3;
   localparam logic [3:0] ST_OFS   = 4'd4;
   localparam logic [3:0] ST_FLOAD = 4'd5;
   localparam logic [3:0] ST_FUPD  = 4'd6;
   localparam logic [3:0] ST_CAL   = 4'd7;
   localparam logic [3:0] ST_CNT   = 4'd8;
   localparam logic [3:0] ST_DLOAD = 4'd9;
   localparam logic [3:0] ST_DIV   = 4'd10;
   localparam logic [3:0] ST_DEND  = 4'd11;
   localparam logic [3:0] ST_FIN   = 4'd12;

   localparam int DIV_W   = isc_pkg::DIV_W;
   localparam int SUM_W   = isc_pkg::SUM_W;
   localparam int DSTEP_W = isc_pkg::DSTEP_W;
   localparam int CNT_W   = isc_pkg::CNT_W;

   logic [3:0]               state_ff, state_in;
   logic [1:0]               axis_ff, axis_in;
   logic                     gyro_ph_ff, gyro_ph_in;
   logic                     filt_ph_ff, filt_ph_in;
   isc_pkg::req_type         req_ff, req_in;

   logic [31:0]              acc_scale_ff, acc_scale_in;
   logic [31:0]              gyr_scale_ff, gyr_scale_in;
   logic signed [31:0]       acc_zero_ff [3];
   logic signed [31:0]       acc_zero_in [3];
   logic signed [31:0]       gyr_zero_ff [3];
   logic signed [31:0]       gyr_zero_in [3];

   logic signed [31:0]       acc_flt_ff [3];
   logic signed [31:0]       acc_flt_in [3];
   logic signed [31:0]       gyr_scl_ff [3];
   logic signed [31:0]       gyr_scl_in [3];
   logic signed [31:0]       gyr_out_ff [3];
   logic signed [31:0]       gyr_out_in [3];
   logic signed [SUM_W-1:0]  sum_ff [3];
   logic signed [SUM_W-1:0]  sum_in [3];
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     active_ff, active_in;
   logic                     done_ff, done_in;
   logic signed [31:0]       avg_ff [3];
   logic signed [31:0]       avg_in [3];

   logic signed [33:0]       mcand_ff, mcand_in;
   logic [15:0]              mplier_ff, mplier_in;
   logic signed [37:0]       hi_ff, hi_in;
   logic [15:0]              lo_ff, lo_in;
   logic [1:0]               dig_ff, dig_in;
   logic signed [31:0]       val_ff, val_in;

   logic [DIV_W-1:0]         rem_ff, rem_in;
   logic [SUM_W-1:0]         dq_ff, dq_in;
   logic [DSTEP_W-1:0]       dstep_ff, dstep_in;
   logic                     neg_ff, neg_in;

   isc_pkg::rsp_type         rsp_ff, rsp_in;
   logic                     rsp_vld_ff, rsp_vld_in;

   logic signed [15:0]       raw_acc [3];
   logic signed [15:0]       raw_gyr [3];
   logic signed [4:0]        digit;
   logic signed [37:0]       mprod;
   logic signed [37:0]       msum;
   logic signed [49:0]       prod;
   logic signed [41:0]       scl_rnd;
   logic signed [31:0]       zero_sel;
   logic signed [32:0]       ofs_diff;
   logic signed [33:0]       fdiff;
   logic signed [34:0]       fupd;
   logic [SUM_W-1:0]         dload;
   logic [DIV_W:0]           trial;
   logic                     trial_ge;
   logic signed [49:0]       qmag;
   logic [CNT_W-1:0]         cnt_inc;
   logic [3:0]               adv_state;
   logic [1:0]               adv_axis;
   logic                     adv_gyro;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   assign raw_acc[0] = req_ff.raw_accel_x;
   assign raw_acc[1] = req_ff.raw_accel_y;
   assign raw_acc[2] = req_ff.raw_accel_z;
   assign raw_gyr[0] = req_ff.raw_gyro_x;
   assign raw_gyr[1] = req_ff.raw_gyro_y;
   assign raw_gyr[2] = req_ff.raw_gyro_z;

   // The top digit of the multiplier carries the sign.
   assign digit = (dig_ff == 2'd3) ? $signed({mplier_ff[3], mplier_ff[3:0]})
                                   : $signed({1'b0, mplier_ff[3:0]});
   assign mprod = 38'(mcand_ff) * 38'(digit);
   assign msum  = hi_ff + mprod;
   assign prod  = $signed({hi_ff[33:0], lo_ff});

   assign scl_rnd  = $signed(prod[49:8]) + $signed({41'b0, prod[7]});
   assign zero_sel = gyro_ph_ff ? gyr_zero_ff[axis_ff] : acc_zero_ff[axis_ff];
   assign ofs_diff = 33'(val_ff) - 33'(zero_sel);
   assign fdiff    = 34'(val_ff) - 34'(acc_flt_ff[axis_ff]);

   // The weights sum to one, so y = prev + round(0.3 * (x - prev)).
   assign fupd = 35'(acc_flt_ff[axis_ff]) + 35'($signed(prod[49:16]))
               + $signed({34'b0, prod[15]});

   // Magnitude plus half the divisor in one add: ~s + 1 + half for negatives.
   assign dload = (sum_ff[axis_ff][SUM_W-1] ? ~sum_ff[axis_ff] : sum_ff[axis_ff])
                + SUM_W'(isc_pkg::CALIB_HALF)
                + SUM_W'(sum_ff[axis_ff][SUM_W-1]);

   assign trial    = {rem_ff, dq_ff[SUM_W-1]};
   assign trial_ge = (trial >= (DIV_W+1)'(isc_pkg::CALIB_SAMPLES));
   assign qmag     = $signed({2'b0, dq_ff});
   assign cnt_inc  = cnt_ff + CNT_W'(1);

   always_comb begin
      adv_axis  = 2'd0;
      adv_gyro  = gyro_ph_ff;
      adv_state = ST_FIN;
      if (axis_ff != 2'd2) begin
         adv_axis  = axis_ff + 2'd1;
         adv_state = ST_MLOAD;
      end else if (!gyro_ph_ff && req_ff.gyro_ready) begin
         adv_gyro  = 1'b1;
         adv_state = ST_MLOAD;
      end else if (active_ff) begin
         adv_state = ST_CAL;
      end
   end

   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      gyro_ph_in   = gyro_ph_ff;
      filt_ph_in   = filt_ph_ff;
      req_in       = req_ff;
      acc_scale_in = acc_scale_ff;
      gyr_scale_in = gyr_scale_ff;
      acc_zero_in  = acc_zero_ff;
      gyr_zero_in  = gyr_zero_ff;
      acc_flt_in   = acc_flt_ff;
      gyr_scl_in   = gyr_scl_ff;
      gyr_out_in   = gyr_out_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      active_in    = active_ff;
      done_in      = done_ff;
      avg_in       = avg_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      hi_in        = hi_ff;
      lo_in        = lo_ff;
      dig_in       = dig_ff;
      val_in       = val_ff;
      rem_in       = rem_ff;
      dq_in        = dq_ff;
      dstep_in     = dstep_ff;
      neg_in       = neg_ff;
      rsp_in       = rsp_ff;
      rsp_vld_in   = rsp_vld_ff && !rsp_ready;

      if (csr_we) begin
         unique case (csr_index)
            isc_pkg::CSR_ACCEL_SCALE:  acc_scale_in   = csr_wdata;
            isc_pkg::CSR_GYRO_SCALE:   gyr_scale_in   = csr_wdata;
            isc_pkg::CSR_ACCEL_ZERO_X: acc_zero_in[0] = $signed(csr_wdata);
            isc_pkg::CSR_ACCEL_ZERO_Y: acc_zero_in[1] = $signed(csr_wdata);
            isc_pkg::CSR_ACCEL_ZERO_Z: acc_zero_in[2] = $signed(csr_wdata);
            isc_pkg::CSR_GYRO_ZERO_X:  gyr_zero_in[0] = $signed(csr_wdata);
            isc_pkg::CSR_GYRO_ZERO_Y:  gyr_zero_in[1] = $signed(csr_wdata);
            isc_pkg::CSR_GYRO_ZERO_Z:  gyr_zero_in[2] = $signed(csr_wdata);
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in     = req_data;
               done_in    = 1'b0;
               axis_in    = 2'd0;
               gyro_ph_in = !req_data.accel_ready;
               for (int i = 0; i < 3; i++) begin
                  avg_in[i] = '0;
               end
               if (req_data.calib_start) begin
                  cnt_in    = '0;
                  active_in = 1'b1;
                  for (int i = 0; i < 3; i++) begin
                     sum_in[i] = '0;
                  end
               end
               if (req_data.accel_ready || req_data.gyro_ready) begin
                  state_in = ST_MLOAD;
               end
            end
         end
         ST_MLOAD: begin
            mcand_in   = $signed({2'b0, (gyro_ph_ff ? gyr_scale_ff : acc_scale_ff)});
            mplier_in  = gyro_ph_ff ? raw_gyr[axis_ff] : raw_acc[axis_ff];
            hi_in      = '0;
            lo_in      = '0;
            dig_in     = 2'd0;
            filt_ph_in = 1'b0;
            state_in   = ST_MUL;
         end
         ST_MUL: begin
            hi_in     = msum >>> 4;
            lo_in     = {msum[3:0], lo_ff[15:4]};
            mplier_in = mplier_ff >> 4;
            dig_in    = dig_ff + 2'd1;
            if (dig_ff == 2'd3) begin
               state_in = filt_ph_ff ? ST_FUPD : ST_SCL;
            end
         end
         ST_SCL: begin
            val_in = isc_pkg::sat32(50'(scl_rnd));
            if (gyro_ph_ff) begin
               gyr_scl_in[axis_ff] = val_in;
            end
            state_in = ST_OFS;
         end
         ST_OFS: begin
            if (gyro_ph_ff) begin
               gyr_out_in[axis_ff] = isc_pkg::sat32(50'(ofs_diff));
               axis_in    = adv_axis;
               gyro_ph_in = adv_gyro;
               state_in   = adv_state;
            end else begin
               val_in   = isc_pkg::sat32(50'(ofs_diff));
               state_in = ST_FLOAD;
            end
         end
         ST_FLOAD: begin
            mcand_in   = fdiff;
            mplier_in  = isc_pkg::COEF_NEW;
            hi_in      = '0;
            lo_in      = '0;
            dig_in     = 2'd0;
            filt_ph_in = 1'b1;
            state_in   = ST_MUL;
         end
         ST_FUPD: begin
            acc_flt_in[axis_ff] = isc_pkg::sat32(50'(fupd));
            axis_in    = adv_axis;
            gyro_ph_in = adv_gyro;
            state_in   = adv_state;
         end
         ST_CAL: begin
            sum_in[axis_ff] = sum_ff[axis_ff] + SUM_W'(gyr_scl_ff[axis_ff]);
            if (axis_ff == 2'd2) begin
               state_in = ST_CNT;
            end else begin
               axis_in = axis_ff + 2'd1;
            end
         end
         ST_CNT: begin
            cnt_in = cnt_inc;
            if (cnt_inc == CNT_W'(isc_pkg::CALIB_SAMPLES)) begin
               active_in = 1'b0;
               done_in   = 1'b1;
               axis_in   = 2'd0;
               state_in  = ST_DLOAD;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_DLOAD: begin
            neg_in   = sum_ff[axis_ff][SUM_W-1];
            dq_in    = dload;
            rem_in   = '0;
            dstep_in = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (trial_ge) begin
               rem_in = DIV_W'(trial - (DIV_W+1)'(isc_pkg::CALIB_SAMPLES));
            end else begin
               rem_in = trial[DIV_W-1:0];
            end
            dq_in    = {dq_ff[SUM_W-2:0], trial_ge};
            dstep_in = dstep_ff + DSTEP_W'(1);
            if (dstep_ff == DSTEP_W'(SUM_W - 1)) begin
               state_in = ST_DEND;
            end
         end
         ST_DEND: begin
            avg_in[axis_ff] = isc_pkg::sat32(neg_ff ? -qmag : qmag);
            if (axis_ff == 2'd2) begin
               state_in = ST_FIN;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = ST_DLOAD;
            end
         end
         ST_FIN: begin
            if (!rsp_vld_ff || rsp_ready) begin
               rsp_in.filt_accel_x = acc_flt_ff[0];
               rsp_in.filt_accel_y = acc_flt_ff[1];
               rsp_in.filt_accel_z = acc_flt_ff[2];
               rsp_in.corr_gyro_x  = gyr_out_ff[0];
               rsp_in.corr_gyro_y  = gyr_out_ff[1];
               rsp_in.corr_gyro_z  = gyr_out_ff[2];
               rsp_in.calib_done   = done_ff;
               rsp_in.avg_gyro_x   = avg_ff[0];
               rsp_in.avg_gyro_y   = avg_ff[1];
               rsp_in.avg_gyro_z   = avg_ff[2];
               rsp_vld_in          = 1'b1;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_vld_ff   <= 1'b0;
         acc_scale_ff <= '0;
         gyr_scale_ff <= '0;
         cnt_ff       <= '0;
         active_ff    <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            acc_zero_ff[i] <= '0;
            gyr_zero_ff[i] <= '0;
            acc_flt_ff[i]  <= '0;
            gyr_scl_ff[i]  <= '0;
            gyr_out_ff[i]  <= '0;
            sum_ff[i]      <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_vld_ff   <= rsp_vld_in;
         acc_scale_ff <= acc_scale_in;
         gyr_scale_ff <= gyr_scale_in;
         cnt_ff       <= cnt_in;
         active_ff    <= active_in;
         acc_zero_ff  <= acc_zero_in;
         gyr_zero_ff  <= gyr_zero_in;
         acc_flt_ff   <= acc_flt_in;
         gyr_scl_ff   <= gyr_scl_in;
         gyr_out_ff   <= gyr_out_in;
         sum_ff       <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      axis_ff    <= axis_in;
      gyro_ph_ff <= gyro_ph_in;
      filt_ph_ff <= filt_ph_in;
      req_ff     <= req_in;
      done_ff    <= done_in;
      avg_ff     <= avg_in;
      mcand_ff   <= mcand_in;
      mplier_ff  <= mplier_in;
      hi_ff      <= hi_in;
      lo_ff      <= lo_in;
      dig_ff     <= dig_in;
      val_ff     <= val_in;
      rem_ff     <= rem_in;
      dq_ff      <= dq_in;
      dstep_ff   <= dstep_in;
      neg_ff     <= neg_in;
      rsp_ff     <= rsp_in;
   end

   // A result that does not complete calibration reports zero means.
   assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && !rsp_ff.calib_done |->
         rsp_ff.avg_gyro_x == 0 && rsp_ff.avg_gyro_y == 0 && rsp_ff.avg_gyro_z == 0)
      else $error("avg fields nonzero without calib_done");

   // While dividing, the divider remainder stays below the divisor.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> rem_ff < DIV_W'(isc_pkg::CALIB_SAMPLES))
      else $error("divider remainder out of range");

   // The calibration count never passes the sample target.
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(isc_pkg::CALIB_SAMPLES))
      else $error("calibration count overrun");

   // An event without a new sample is dropped in the transfer cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_data.accel_ready && !req_data.gyro_ready |=>
         state_ff == ST_IDLE)
      else $error("event without samples started processing");

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// IMU sample conditioning unit testbench
// Drives data-ready events through the request channel with bursty pacing.
// A local predictor tracks the filter, offset and calibration state and
// works out each conditioned result, which is checked field by field against
// the response channel. Register settings change between phases while the
// unit is idle.
// ----------------------------------------------------------------------------
module tb;

   localparam int     CLK_HALF       = 10;
   localparam int     DRAIN_CYCLES   = 300;
   localparam longint TIMEOUT_CYCLES = 10_000_000;
   localparam longint S32_TOP        = 64'sh0000_0000_7FFF_FFFF;
   localparam longint S32_BOTTOM     = -S32_TOP - 1;
   localparam longint LPF_NEW        = 19661;
   localparam longint LPF_OLD        = 45875;
   localparam logic [31:0] GAIN_ONE  = 32'h0100_0000;
   localparam logic [31:0] GAIN_TOP  = 32'hFFFF_FFFF;
   localparam logic [31:0] ZERO_TOP  = 32'h7FFF_FFFF;
   localparam logic [31:0] ZERO_LOW  = 32'h8000_0000;

   typedef enum int {RX_OPEN, RX_SPARSE, RX_CHOKED} rx_mode_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   isc_pkg::req_type              req_data = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   isc_pkg::rsp_type              rsp_data;
   logic                          csr_we = 1'b0;
   logic [isc_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]                   csr_wdata = '0;

   isc_pkg::req_type sensor_events[$];
   isc_pkg::rsp_type pending_results[$];

   bit          req_fire = 1'b0;
   int          burst_left = 0;
   int          gap_left = 0;
   int          rx_left = 0;
   rx_mode_type rx_mode = RX_OPEN;
   int          mismatch_count = 0;
   int          result_count = 0;

   logic [31:0]        acc_gain = '0;
   logic [31:0]        gyr_gain = '0;
   logic signed [31:0] acc_offset[3] = '{default: '0};
   logic signed [31:0] gyr_offset[3] = '{default: '0};

   logic signed [31:0] lpf_state[3] = '{default: '0};
   logic signed [31:0] gyr_scaled[3] = '{default: '0};
   logic signed [31:0] gyr_corr[3] = '{default: '0};
   longint             cal_sum[3] = '{default: 0};
   logic [15:0]        cal_count = '0;
   bit                 cal_running = 1'b0;

   string field_tag[10] = '{"filt_accel_x", "filt_accel_y", "filt_accel_z",
                            "corr_gyro_x", "corr_gyro_y", "corr_gyro_z", "calib_done",
                            "avg_gyro_x", "avg_gyro_y", "avg_gyro_z"};

   imu_sample_condition_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #CLK_HALF clock = ~clock;
   end

   initial begin
      #(TIMEOUT_CYCLES * 2 * CLK_HALF);
      $display("Regression FAIL");
      $finish;
   end

   function automatic logic signed [31:0] clamp_s32(input longint v);
      if (v > S32_TOP) begin
         return 32'h7FFF_FFFF;
      end else if (v < S32_BOTTOM) begin
         return 32'h8000_0000;
      end
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] scaled_sample(input logic signed [15:0] raw,
                                                        input logic [31:0] gain);
      longint prod;
      prod = longint'(raw) * longint'({32'h0, gain});
      return clamp_s32((prod + 128) >>> 8);
   endfunction

   function automatic logic signed [31:0] calib_mean(input longint s);
      longint n;
      n = longint'(isc_pkg::CALIB_SAMPLES);
      if (s >= 0) begin
         return clamp_s32((s + n / 2) / n);
      end
      return clamp_s32(-((-s + n / 2) / n));
   endfunction

   function automatic bit condition_event(input isc_pkg::req_type e,
                                          output isc_pkg::rsp_type r);
      logic signed [15:0] acc_raw[3];
      logic signed [15:0] gyr_raw[3];
      logic signed [31:0] x;
      logic signed [31:0] mean[3];
      longint             lpf;
      bit                 done;
      acc_raw = '{e.raw_accel_x, e.raw_accel_y, e.raw_accel_z};
      gyr_raw = '{e.raw_gyro_x, e.raw_gyro_y, e.raw_gyro_z};
      mean = '{default: '0};
      done = 1'b0;
      r = '0;
      if (e.calib_start) begin
         cal_count = '0;
         cal_sum = '{default: 0};
         cal_running = 1'b1;
      end
      if (!e.accel_ready && !e.gyro_ready) begin
         return 1'b0;
      end
      if (e.accel_ready) begin
         for (int i = 0; i < 3; i++) begin
            x = clamp_s32(longint'(scaled_sample(acc_raw[i], acc_gain))
                          - longint'(acc_offset[i]));
            lpf = LPF_NEW * longint'(x) + LPF_OLD * longint'(lpf_state[i]) + 32768;
            lpf_state[i] = clamp_s32(lpf >>> 16);
         end
      end
      if (e.gyro_ready) begin
         for (int i = 0; i < 3; i++) begin
            gyr_scaled[i] = scaled_sample(gyr_raw[i], gyr_gain);
            gyr_corr[i] = clamp_s32(longint'(gyr_scaled[i]) - longint'(gyr_offset[i]));
         end
      end
      if (cal_running) begin
         for (int i = 0; i < 3; i++) begin
            cal_sum[i] += longint'(gyr_scaled[i]);
         end
         cal_count = cal_count + 16'd1;
         if (cal_count == 16'(isc_pkg::CALIB_SAMPLES)) begin
            cal_running = 1'b0;
            done = 1'b1;
            for (int i = 0; i < 3; i++) begin
               mean[i] = calib_mean(cal_sum[i]);
            end
         end
      end
      r.filt_accel_x = lpf_state[0];
      r.filt_accel_y = lpf_state[1];
      r.filt_accel_z = lpf_state[2];
      r.corr_gyro_x = gyr_corr[0];
      r.corr_gyro_y = gyr_corr[1];
      r.corr_gyro_z = gyr_corr[2];
      r.calib_done = done;
      r.avg_gyro_x = mean[0];
      r.avg_gyro_y = mean[1];
      r.avg_gyro_z = mean[2];
      return 1'b1;
   endfunction

   function automatic void check_result(input isc_pkg::rsp_type got,
                                        input isc_pkg::rsp_type want);
      logic [31:0] g[10];
      logic [31:0] w[10];
      g = '{got.filt_accel_x, got.filt_accel_y, got.filt_accel_z, got.corr_gyro_x,
            got.corr_gyro_y, got.corr_gyro_z, 32'(got.calib_done), got.avg_gyro_x,
            got.avg_gyro_y, got.avg_gyro_z};
      w = '{want.filt_accel_x, want.filt_accel_y, want.filt_accel_z, want.corr_gyro_x,
            want.corr_gyro_y, want.corr_gyro_z, 32'(want.calib_done), want.avg_gyro_x,
            want.avg_gyro_y, want.avg_gyro_z};
      for (int i = 0; i < 10; i++) begin
         if (g[i] !== w[i]) begin
            if (mismatch_count < 10) begin
               $display("Mismatch in result %0d, %s: expected %h, actual %h",
                        result_count, field_tag[i], w[i], g[i]);
            end
            mismatch_count++;
         end
      end
   endfunction

   // Every transfer on the request side updates the predictor at the same edge.
   always @(posedge clock) begin
      isc_pkg::rsp_type want;
      if (reset) begin
         req_fire = 1'b0;
      end else begin
         req_fire = req_valid && req_ready;
         if (req_fire && condition_event(req_data, want)) begin
            pending_results.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               if (mismatch_count < 10) begin
                  $display("Result %0d arrived with none expected: %h",
                           result_count, rsp_data);
               end
               mismatch_count++;
            end else begin
               check_result(rsp_data, pending_results.pop_front());
            end
            result_count++;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (gap_left != 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (sensor_events.size() != 0) begin
            req_data <= sensor_events.pop_front();
            req_valid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
            end else begin
               burst_left--;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (rx_left == 0) begin
         rx_left = $urandom_range(16, 400);
         rx_mode = rx_mode_type'($urandom_range(0, 2));
      end else begin
         rx_left--;
      end
      if (rx_mode == RX_OPEN) begin
         rsp_ready <= 1'b1;
      end else if (rx_mode == RX_SPARSE) begin
         rsp_ready <= ($urandom_range(0, 2) != 0);
      end else begin
         rsp_ready <= ($urandom_range(0, 11) == 0);
      end
   end

   function automatic isc_pkg::req_type build_event(input bit a, input bit g,
                                                    input logic signed [15:0] ax, ay, az,
                                                    input logic signed [15:0] gx, gy, gz,
                                                    input bit start);
      isc_pkg::req_type e;
      e.accel_ready = a;
      e.gyro_ready = g;
      e.raw_accel_x = ax;
      e.raw_accel_y = ay;
      e.raw_accel_z = az;
      e.raw_gyro_x = gx;
      e.raw_gyro_y = gy;
      e.raw_gyro_z = gz;
      e.calib_start = start;
      return e;
   endfunction

   function automatic logic signed [15:0] pick_raw();
      int unsigned sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
         case ($urandom_range(0, 4))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh0000;
            3: return 16'shFFFF;
            default: return 16'sh0001;
         endcase
      end else if (sel < 3) begin
         return 16'($urandom_range(0, 511)) - 16'd256;
      end
      return 16'($urandom());
   endfunction

   function automatic isc_pkg::req_type random_event();
      int unsigned sel;
      sel = $urandom_range(0, 99);
      return build_event(sel < 60, sel < 40 || (sel >= 60 && sel < 85),
                         pick_raw(), pick_raw(), pick_raw(),
                         pick_raw(), pick_raw(), pick_raw(),
                         $urandom_range(0, 39) == 0);
   endfunction

   function automatic logic [31:0] small_offset();
      logic [31:0] v;
      v = $urandom_range(0, 32'h0003_FFFF);
      return v - 32'h0002_0000;
   endfunction

   task automatic write_csr(input logic [isc_pkg::CSR_IDX_W-1:0] idx,
                            input logic [31:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         isc_pkg::CSR_ACCEL_SCALE:  acc_gain = val;
         isc_pkg::CSR_GYRO_SCALE:   gyr_gain = val;
         isc_pkg::CSR_ACCEL_ZERO_X: acc_offset[0] = val;
         isc_pkg::CSR_ACCEL_ZERO_Y: acc_offset[1] = val;
         isc_pkg::CSR_ACCEL_ZERO_Z: acc_offset[2] = val;
         isc_pkg::CSR_GYRO_ZERO_X:  gyr_offset[0] = val;
         isc_pkg::CSR_GYRO_ZERO_Y:  gyr_offset[1] = val;
         default:                   gyr_offset[2] = val;
      endcase
   endtask

   task automatic apply_setting(input logic [31:0] a_gain, g_gain,
                                input logic [31:0] azx, azy, azz, gzx, gzy, gzz);
      write_csr(isc_pkg::CSR_ACCEL_SCALE, a_gain);
      write_csr(isc_pkg::CSR_GYRO_SCALE, g_gain);
      write_csr(isc_pkg::CSR_ACCEL_ZERO_X, azx);
      write_csr(isc_pkg::CSR_ACCEL_ZERO_Y, azy);
      write_csr(isc_pkg::CSR_ACCEL_ZERO_Z, azz);
      write_csr(isc_pkg::CSR_GYRO_ZERO_X, gzx);
      write_csr(isc_pkg::CSR_GYRO_ZERO_Y, gzy);
      write_csr(isc_pkg::CSR_GYRO_ZERO_Z, gzz);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Returns once every event has been transferred, every result has been
   // checked and the unit has had time to finish an event with no result.
   task automatic wait_idle();
      @(posedge clock);
      while (sensor_events.size() != 0 || req_valid || pending_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_random(input int n);
      repeat (n) sensor_events.push_back(random_event());
      wait_idle();
   endtask

   initial begin
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      apply_setting(GAIN_ONE, GAIN_ONE, small_offset(), small_offset(), small_offset(),
                    small_offset(), small_offset(), small_offset());
      sensor_events.push_back(build_event(1, 0, 16'sh7FFF, 16'sh8000, 0, 5, 6, 7, 1));
      sensor_events.push_back(build_event(0, 1, 1, 2, 3, 16'sh7FFF, 16'sh8000, -1, 0));
      sensor_events.push_back(build_event(1, 1, 16'sh8000, 16'sh7FFF, -1, 1, 0, -1, 0));
      sensor_events.push_back(build_event(0, 0, 100, 200, 300, 400, 500, 600, 0));
      sensor_events.push_back(build_event(0, 0, 0, 0, 0, 0, 0, 0, 1));
      sensor_events.push_back(build_event(1, 0, 1234, -4321, 77, 9, 9, 9, 0));
      sensor_events.push_back(build_event(0, 1, -5, 5, -5, 300, -300, 3000, 0));
      sensor_events.push_back(build_event(1, 1, 10, 20, 30, -40, -50, -60, 1));
      sensor_events.push_back(build_event(1, 1, 0, 0, 0, 0, 0, 0, 0));
      sensor_events.push_back(build_event(1, 1, -1, -1, -1, -1, -1, -1, 0));
      sensor_events.push_back(build_event(1, 0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                                          0, 0, 0, 0));
      sensor_events.push_back(build_event(0, 1, 0, 0, 0, 16'sh8000, 16'sh8000,
                                          16'sh8000, 0));
      sensor_events.push_back(build_event(0, 0, 16'sh7FFF, 0, 0, 0, 0, 0, 1));
      repeat (6) sensor_events.push_back(random_event());
      wait_idle();

      apply_setting(GAIN_TOP, GAIN_TOP, ZERO_LOW, ZERO_TOP, ZERO_LOW,
                    ZERO_TOP, ZERO_LOW, ZERO_TOP);
      sensor_events.push_back(build_event(1, 1, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                                          16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1));
      sensor_events.push_back(build_event(1, 1, 16'sh8000, 16'sh8000, 16'sh8000,
                                          16'sh8000, 16'sh8000, 16'sh8000, 0));
      sensor_events.push_back(build_event(1, 1, 0, 0, 0, 0, 0, 0, 0));
      sensor_events.push_back(build_event(1, 1, 1, -1, 1, -1, 1, -1, 0));
      run_random(200);

      apply_setting(32'h0, 32'h0, $urandom(), $urandom(), $urandom(),
                    $urandom(), $urandom(), $urandom());
      run_random(150);

      apply_setting(32'h8000_0000, 32'h8000_0000, ZERO_TOP, ZERO_LOW, ZERO_TOP,
                    ZERO_LOW, ZERO_TOP, ZERO_LOW);
      run_random(150);

      apply_setting($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                    $urandom(), $urandom(), $urandom());
      run_random(300);

      apply_setting($urandom_range(0, 32'h0400_0000), $urandom_range(0, 32'h0400_0000),
                    small_offset(), small_offset(), small_offset(),
                    small_offset(), small_offset(), small_offset());
      run_random(550);

      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
